// ===== hw/rtl/ecf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ellipse contact function package
// Shared types, fixed-point constants, register-file map and the microcode
// that drives one Newton step of the contact search.
// ----------------------------------------------------------------------------
package ecf_pkg;

    typedef logic signed [63:0] q32_t;

    localparam q32_t ONE_Q32  = 64'sh0000_0001_0000_0000;
    localparam q32_t HALF_Q32 = 64'sh0000_0000_8000_0000;
    localparam q32_t MAX_Q32  = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam q32_t MIN_Q32  = 64'sh8000_0000_0000_0000;

    localparam int RF_AW = 6;
    localparam int PC_W  = 7;
    localparam logic [PC_W-1:0] UCODE_LAST = 7'd104;

    localparam logic [1:0] ST_CONVERGED = 2'd0;
    localparam logic [1:0] ST_SEPARATED = 2'd1;
    localparam logic [1:0] ST_NO_CONV   = 2'd2;

    localparam logic [31:0] PORT_POS_SAT = 32'h7FFF_FFFF;
    localparam logic [31:0] PORT_MINUS_ONE = 32'hFFFF_0000;
    localparam logic [31:0] TOL_RESET = 32'd43;

    typedef struct packed {
        logic signed [31:0] offset_x;
        logic signed [31:0] offset_y;
        logic signed [31:0] first_m11;
        logic signed [31:0] first_m12;
        logic signed [31:0] first_m21;
        logic signed [31:0] first_m22;
        logic signed [31:0] second_m11;
        logic signed [31:0] second_m12;
        logic signed [31:0] second_m21;
        logic signed [31:0] second_m22;
    } in_beat_t;

    typedef struct packed {
        logic signed [31:0] contact_value;
        logic [1:0]         finish_status;
    } out_beat_t;

    typedef enum logic [2:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_NEG,
        ALU_MUL,
        ALU_DIV
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

    typedef struct packed {
        logic done;
        q32_t y;
    } alu_rsp_t;

    typedef enum logic [2:0] {
        U_ADD,
        U_SUB,
        U_NEG,
        U_MUL,
        U_DIV,
        U_CHKDET,
        U_TEST,
        U_STEP
    } uop_t;

    typedef logic [RF_AW-1:0] raddr_t;

    typedef struct packed {
        uop_t   op;
        raddr_t dst;
        raddr_t a;
        raddr_t b;
    } inst_t;

    localparam raddr_t R_RX = 6'd0;
    localparam raddr_t R_RY = 6'd1;
    localparam raddr_t R_AA = 6'd2;
    localparam raddr_t R_AB = 6'd3;
    localparam raddr_t R_AC = 6'd4;
    localparam raddr_t R_AD = 6'd5;
    localparam raddr_t R_BA = 6'd6;
    localparam raddr_t R_BB = 6'd7;
    localparam raddr_t R_BC = 6'd8;
    localparam raddr_t R_BD = 6'd9;
    localparam raddr_t R_T = 6'd10;
    localparam raddr_t R_ONE = 6'd11;
    localparam raddr_t R_S = 6'd12;
    localparam raddr_t R_GA = 6'd13;
    localparam raddr_t R_GB = 6'd14;
    localparam raddr_t R_GC = 6'd15;
    localparam raddr_t R_GD = 6'd16;
    localparam raddr_t R_DA = 6'd17;
    localparam raddr_t R_DB = 6'd18;
    localparam raddr_t R_DC = 6'd19;
    localparam raddr_t R_DD = 6'd20;
    localparam raddr_t R_DET = 6'd21;
    localparam raddr_t R_DR0 = 6'd22;
    localparam raddr_t R_DR1 = 6'd23;
    localparam raddr_t R_U0 = 6'd24;
    localparam raddr_t R_U1 = 6'd25;
    localparam raddr_t R_DADR0 = 6'd26;
    localparam raddr_t R_DADR1 = 6'd27;
    localparam raddr_t R_DBDR0 = 6'd28;
    localparam raddr_t R_DBDR1 = 6'd29;
    localparam raddr_t R_DADBDR0 = 6'd30;
    localparam raddr_t R_DADBDR1 = 6'd31;
    localparam raddr_t R_DBDADR0 = 6'd32;
    localparam raddr_t R_DBDADR1 = 6'd33;
    localparam raddr_t R_P = 6'd34;
    localparam raddr_t R_Q = 6'd35;
    localparam raddr_t R_W = 6'd36;
    localparam raddr_t R_F = 6'd37;
    localparam raddr_t R_DF = 6'd38;
    localparam raddr_t R_DDF = 6'd39;
    localparam raddr_t R_DT = 6'd40;
    localparam raddr_t R_T1 = 6'd41;

    function automatic inst_t mk(uop_t op, raddr_t d, raddr_t a, raddr_t b);
        inst_t i;
        i.op  = op;
        i.dst = d;
        i.a   = a;
        i.b   = b;
        return i;
    endfunction

    function automatic inst_t ucode(logic [PC_W-1:0] pc);
        inst_t i;
        unique case (pc)
            7'd0:   i = mk(U_SUB, R_S, R_ONE, R_T);
            7'd1:   i = mk(U_MUL, R_P, R_S, R_AA);
            7'd2:   i = mk(U_MUL, R_Q, R_T, R_BA);
            7'd3:   i = mk(U_ADD, R_GA, R_P, R_Q);
            7'd4:   i = mk(U_MUL, R_P, R_S, R_AB);
            7'd5:   i = mk(U_MUL, R_Q, R_T, R_BB);
            7'd6:   i = mk(U_ADD, R_GB, R_P, R_Q);
            7'd7:   i = mk(U_MUL, R_P, R_S, R_AC);
            7'd8:   i = mk(U_MUL, R_Q, R_T, R_BC);
            7'd9:   i = mk(U_ADD, R_GC, R_P, R_Q);
            7'd10:  i = mk(U_MUL, R_P, R_S, R_AD);
            7'd11:  i = mk(U_MUL, R_Q, R_T, R_BD);
            7'd12:  i = mk(U_ADD, R_GD, R_P, R_Q);
            7'd13:  i = mk(U_MUL, R_P, R_GA, R_GD);
            7'd14:  i = mk(U_MUL, R_Q, R_GB, R_GC);
            7'd15:  i = mk(U_SUB, R_DET, R_P, R_Q);
            7'd16:  i = mk(U_CHKDET, R_DET, R_DET, R_DET);
            7'd17:  i = mk(U_DIV, R_DA, R_GD, R_DET);
            7'd18:  i = mk(U_NEG, R_P, R_GB, R_GB);
            7'd19:  i = mk(U_DIV, R_DB, R_P, R_DET);
            7'd20:  i = mk(U_NEG, R_P, R_GC, R_GC);
            7'd21:  i = mk(U_DIV, R_DC, R_P, R_DET);
            7'd22:  i = mk(U_DIV, R_DD, R_GA, R_DET);
            7'd23:  i = mk(U_MUL, R_P, R_DA, R_RX);
            7'd24:  i = mk(U_MUL, R_Q, R_DB, R_RY);
            7'd25:  i = mk(U_ADD, R_DR0, R_P, R_Q);
            7'd26:  i = mk(U_MUL, R_P, R_DC, R_RX);
            7'd27:  i = mk(U_MUL, R_Q, R_DD, R_RY);
            7'd28:  i = mk(U_ADD, R_DR1, R_P, R_Q);
            7'd29:  i = mk(U_MUL, R_P, R_AA, R_DR0);
            7'd30:  i = mk(U_MUL, R_Q, R_AB, R_DR1);
            7'd31:  i = mk(U_ADD, R_U0, R_P, R_Q);
            7'd32:  i = mk(U_MUL, R_P, R_AC, R_DR0);
            7'd33:  i = mk(U_MUL, R_Q, R_AD, R_DR1);
            7'd34:  i = mk(U_ADD, R_U1, R_P, R_Q);
            7'd35:  i = mk(U_MUL, R_P, R_DA, R_U0);
            7'd36:  i = mk(U_MUL, R_Q, R_DB, R_U1);
            7'd37:  i = mk(U_ADD, R_DADR0, R_P, R_Q);
            7'd38:  i = mk(U_MUL, R_P, R_DC, R_U0);
            7'd39:  i = mk(U_MUL, R_Q, R_DD, R_U1);
            7'd40:  i = mk(U_ADD, R_DADR1, R_P, R_Q);
            7'd41:  i = mk(U_MUL, R_P, R_BA, R_DR0);
            7'd42:  i = mk(U_MUL, R_Q, R_BB, R_DR1);
            7'd43:  i = mk(U_ADD, R_U0, R_P, R_Q);
            7'd44:  i = mk(U_MUL, R_P, R_BC, R_DR0);
            7'd45:  i = mk(U_MUL, R_Q, R_BD, R_DR1);
            7'd46:  i = mk(U_ADD, R_U1, R_P, R_Q);
            7'd47:  i = mk(U_MUL, R_P, R_DA, R_U0);
            7'd48:  i = mk(U_MUL, R_Q, R_DB, R_U1);
            7'd49:  i = mk(U_ADD, R_DBDR0, R_P, R_Q);
            7'd50:  i = mk(U_MUL, R_P, R_DC, R_U0);
            7'd51:  i = mk(U_MUL, R_Q, R_DD, R_U1);
            7'd52:  i = mk(U_ADD, R_DBDR1, R_P, R_Q);
            7'd53:  i = mk(U_MUL, R_P, R_AA, R_DBDR0);
            7'd54:  i = mk(U_MUL, R_Q, R_AB, R_DBDR1);
            7'd55:  i = mk(U_ADD, R_U0, R_P, R_Q);
            7'd56:  i = mk(U_MUL, R_P, R_AC, R_DBDR0);
            7'd57:  i = mk(U_MUL, R_Q, R_AD, R_DBDR1);
            7'd58:  i = mk(U_ADD, R_U1, R_P, R_Q);
            7'd59:  i = mk(U_MUL, R_P, R_DA, R_U0);
            7'd60:  i = mk(U_MUL, R_Q, R_DB, R_U1);
            7'd61:  i = mk(U_ADD, R_DADBDR0, R_P, R_Q);
            7'd62:  i = mk(U_MUL, R_P, R_DC, R_U0);
            7'd63:  i = mk(U_MUL, R_Q, R_DD, R_U1);
            7'd64:  i = mk(U_ADD, R_DADBDR1, R_P, R_Q);
            7'd65:  i = mk(U_MUL, R_P, R_BA, R_DADR0);
            7'd66:  i = mk(U_MUL, R_Q, R_BB, R_DADR1);
            7'd67:  i = mk(U_ADD, R_U0, R_P, R_Q);
            7'd68:  i = mk(U_MUL, R_P, R_BC, R_DADR0);
            7'd69:  i = mk(U_MUL, R_Q, R_BD, R_DADR1);
            7'd70:  i = mk(U_ADD, R_U1, R_P, R_Q);
            7'd71:  i = mk(U_MUL, R_P, R_DA, R_U0);
            7'd72:  i = mk(U_MUL, R_Q, R_DB, R_U1);
            7'd73:  i = mk(U_ADD, R_DBDADR0, R_P, R_Q);
            7'd74:  i = mk(U_MUL, R_P, R_DC, R_U0);
            7'd75:  i = mk(U_MUL, R_Q, R_DD, R_U1);
            7'd76:  i = mk(U_ADD, R_DBDADR1, R_P, R_Q);
            7'd77:  i = mk(U_MUL, R_W, R_S, R_T);
            7'd78:  i = mk(U_MUL, R_P, R_RX, R_DR0);
            7'd79:  i = mk(U_MUL, R_Q, R_RY, R_DR1);
            7'd80:  i = mk(U_ADD, R_P, R_P, R_Q);
            7'd81:  i = mk(U_MUL, R_F, R_W, R_P);
            7'd82:  i = mk(U_MUL, R_W, R_S, R_S);
            7'd83:  i = mk(U_MUL, R_P, R_RX, R_DADR0);
            7'd84:  i = mk(U_MUL, R_Q, R_RY, R_DADR1);
            7'd85:  i = mk(U_ADD, R_P, R_P, R_Q);
            7'd86:  i = mk(U_MUL, R_DF, R_W, R_P);
            7'd87:  i = mk(U_MUL, R_W, R_T, R_T);
            7'd88:  i = mk(U_MUL, R_P, R_RX, R_DBDR0);
            7'd89:  i = mk(U_MUL, R_Q, R_RY, R_DBDR1);
            7'd90:  i = mk(U_ADD, R_P, R_P, R_Q);
            7'd91:  i = mk(U_MUL, R_W, R_W, R_P);
            7'd92:  i = mk(U_SUB, R_DF, R_DF, R_W);
            7'd93:  i = mk(U_MUL, R_P, R_RX, R_DADBDR0);
            7'd94:  i = mk(U_MUL, R_Q, R_RY, R_DADBDR1);
            7'd95:  i = mk(U_ADD, R_W, R_P, R_Q);
            7'd96:  i = mk(U_MUL, R_P, R_RX, R_DBDADR0);
            7'd97:  i = mk(U_MUL, R_Q, R_RY, R_DBDADR1);
            7'd98:  i = mk(U_ADD, R_P, R_P, R_Q);
            7'd99:  i = mk(U_ADD, R_P, R_W, R_P);
            7'd100: i = mk(U_NEG, R_DDF, R_P, R_P);
            7'd101: i = mk(U_TEST, R_DF, R_DF, R_F);
            7'd102: i = mk(U_DIV, R_DT, R_DF, R_DDF);
            7'd103: i = mk(U_SUB, R_T1, R_T, R_DT);
            7'd104: i = mk(U_STEP, R_T, R_T, R_T1);
            default: i = mk(U_STEP, R_T, R_T, R_T1);
        endcase
        return i;
    endfunction

endpackage

// ===== hw/rtl/ecf_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ellipse contact shared arithmetic unit
// Saturating Q32.32 add, subtract, negate, multiply (four 32x32 partial
// products) and divide (one quotient bit per cycle), all rounded to nearest.
// ----------------------------------------------------------------------------
module ecf_alu (
    input  logic                clk,
    input  logic                rst_n,
    input  ecf_pkg::alu_req_t   req,
    input  ecf_pkg::q32_t       a,
    input  ecf_pkg::q32_t       b,
    output ecf_pkg::alu_rsp_t   rsp
);

    typedef enum logic [4:0] {
        A_IDLE = 5'b00001,
        A_MUL  = 5'b00010,
        A_MFIN = 5'b00100,
        A_DIV  = 5'b01000,
        A_DFIN = 5'b10000
    } astate_t;

    astate_t        state_reg, state_next;
    logic [5:0]     cnt_reg, cnt_next;
    logic [63:0]    ma_reg, ma_next;
    logic [63:0]    mb_reg, mb_next;
    logic           neg_reg, neg_next;
    logic [127:0]   acc_reg, acc_next;
    logic [63:0]    rem_reg, rem_next;
    logic [63:0]    sh_reg, sh_next;
    logic [63:0]    q_reg, q_next;
    ecf_pkg::q32_t  y_reg, y_next;
    logic           done_reg, done_next;

    logic [63:0]    ma_in, mb_in;
    logic [31:0]    pa, pb;
    logic [63:0]    pp;
    logic [127:0]   pp_sh;
    logic [127:0]   rnd;
    logic [64:0]    rem_sh;
    logic [64:0]    rem_sub;

    function automatic logic [63:0] mag(ecf_pkg::q32_t v);
        return v[63] ? (64'd0 - 64'(v)) : 64'(v);
    endfunction

    function automatic ecf_pkg::q32_t from_mag(logic [63:0] m, logic neg);
        ecf_pkg::q32_t r;
        if (neg)
        begin
            r = m[63] ? ecf_pkg::MIN_Q32 : ecf_pkg::q32_t'(64'd0 - m);
        end
        else
        begin
            r = m[63] ? ecf_pkg::MAX_Q32 : ecf_pkg::q32_t'(m);
        end
        return r;
    endfunction

    function automatic ecf_pkg::q32_t sat65(logic [64:0] s);
        ecf_pkg::q32_t r;
        if (s[64] != s[63])
        begin
            r = s[64] ? ecf_pkg::MIN_Q32 : ecf_pkg::MAX_Q32;
        end
        else
        begin
            r = ecf_pkg::q32_t'(s[63:0]);
        end
        return r;
    endfunction

    assign ma_in = mag(a);
    assign mb_in = mag(b);

    assign pa = cnt_reg[1] ? ma_reg[63:32] : ma_reg[31:0];
    assign pb = cnt_reg[0] ? mb_reg[63:32] : mb_reg[31:0];
    assign pp = 64'(pa) * 64'(pb);

    always_comb
    begin
        unique case (cnt_reg[1:0])
            2'd0:    pp_sh = {64'd0, pp};
            2'd3:    pp_sh = {pp, 64'd0};
            default: pp_sh = {32'd0, pp, 32'd0};
        endcase
    end

    assign rnd     = acc_reg + 128'h8000_0000;
    assign rem_sh  = {rem_reg, sh_reg[63]};
    assign rem_sub = rem_sh - {1'b0, mb_reg};

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        sh_next    = sh_reg;
        q_next     = q_reg;
        y_next     = y_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            A_IDLE:
            begin
                if (req.start)
                begin
                    ma_next  = ma_in;
                    mb_next  = mb_in;
                    neg_next = a[63] ^ b[63];
                    cnt_next = '0;
                    unique case (req.op)
                        ecf_pkg::ALU_ADD:
                        begin
                            y_next    = sat65({a[63], a} + {b[63], b});
                            done_next = 1'b1;
                        end
                        ecf_pkg::ALU_SUB:
                        begin
                            y_next    = sat65({a[63], a} - {b[63], b});
                            done_next = 1'b1;
                        end
                        ecf_pkg::ALU_NEG:
                        begin
                            y_next    = (a == ecf_pkg::MIN_Q32) ? ecf_pkg::MAX_Q32 : -a;
                            done_next = 1'b1;
                        end
                        ecf_pkg::ALU_MUL:
                        begin
                            acc_next   = '0;
                            state_next = A_MUL;
                        end
                        ecf_pkg::ALU_DIV:
                        begin
                            if (mb_in == 64'd0)
                            begin
                                if (ma_in == 64'd0)
                                begin
                                    y_next = '0;
                                end
                                else
                                begin
                                    y_next = a[63] ? ecf_pkg::MIN_Q32 : ecf_pkg::MAX_Q32;
                                end
                                done_next = 1'b1;
                            end
                            else if ({32'd0, ma_in[63:32]} >= mb_in)
                            begin
                                y_next    = from_mag('1, a[63] ^ b[63]);
                                done_next = 1'b1;
                            end
                            else
                            begin
                                rem_next   = {32'd0, ma_in[63:32]};
                                sh_next    = {ma_in[31:0], 32'd0};
                                q_next     = '0;
                                state_next = A_DIV;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            A_MUL:
            begin
                acc_next = acc_reg + pp_sh;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg[1:0] == 2'd3)
                begin
                    state_next = A_MFIN;
                end
            end
            A_MFIN:
            begin
                if (|rnd[127:96])
                begin
                    y_next = from_mag('1, neg_reg);
                end
                else
                begin
                    y_next = from_mag(rnd[95:32], neg_reg);
                end
                done_next  = 1'b1;
                state_next = A_IDLE;
            end
            A_DIV:
            begin
                if (!rem_sub[64])
                begin
                    rem_next = rem_sub[63:0];
                    q_next   = {q_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[63:0];
                    q_next   = {q_reg[62:0], 1'b0};
                end
                sh_next  = {sh_reg[62:0], 1'b0};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    state_next = A_DFIN;
                end
            end
            A_DFIN:
            begin
                if (rem_reg >= (mb_reg - rem_reg))
                begin
                    y_next = (&q_reg) ? from_mag('1, neg_reg)
                                      : from_mag(q_reg + 64'd1, neg_reg);
                end
                else
                begin
                    y_next = from_mag(q_reg, neg_reg);
                end
                done_next  = 1'b1;
                state_next = A_IDLE;
            end
            default:
            begin
                state_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ma_reg  <= ma_next;
        mb_reg  <= mb_next;
        neg_reg <= neg_next;
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        q_reg   <= q_next;
        y_reg   <= y_next;
    end

    assign rsp.done = done_reg;
    assign rsp.y    = y_reg;

endmodule

// ===== hw/rtl/ellipse_contact_function.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ellipse contact function
// Two-dimensional contact value of two ellipses by a bounded Newton search,
// run as microcode on one shared Q32.32 arithmetic unit.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy then stays high
// until the single result beat, which is shown on result with done high for
// one cycle and cannot be held off. The ten item fields are loaded into the
// register file with the constants one half and one. Each Newton step runs
// 105 micro-operations, each with operand fetch and issue; an add ends in the
// unit's idle state, while a multiply (four 32x32 partial products) and a
// division that does not saturate (one quotient bit a cycle) each end with
// rounding and the result beat. An item runs up to ITERATIONS steps.
// ----------------------------------------------------------------------------
module ellipse_contact_function #(
    parameter int ITERATIONS = 20
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  ecf_pkg::in_beat_t    item,
    input  logic                 cfg_we,
    input  logic [31:0]          cfg_data,
    output logic                 done,
    output ecf_pkg::out_beat_t   result
);

    localparam int IW = (ITERATIONS > 1) ? $clog2(ITERATIONS) : 1;
    localparam int RF_DEPTH = 1 << ecf_pkg::RF_AW;
    localparam logic [ecf_pkg::PC_W-1:0] PC_STEP = 1;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_LOAD  = 5'b00010,
        S_FETCH = 5'b00100,
        S_OPER  = 5'b01000,
        S_WAIT  = 5'b10000
    } state_t;

    state_t                      state_reg, state_next;
    logic [ecf_pkg::PC_W-1:0]    pc_reg, pc_next;
    logic [IW-1:0]               iter_reg, iter_next;
    logic [3:0]                  load_reg, load_next;
    logic [31:0]                 tol_reg;
    ecf_pkg::in_beat_t           item_reg;
    ecf_pkg::out_beat_t          res_reg, res_next;
    logic                        done_reg, done_next;

    ecf_pkg::q32_t               rf [RF_DEPTH];
    ecf_pkg::q32_t               rda_reg, rdb_reg;

    ecf_pkg::inst_t              inst;
    logic                        wr_en;
    ecf_pkg::raddr_t             wr_addr;
    ecf_pkg::q32_t               wr_data;
    ecf_pkg::q32_t               load_val;
    ecf_pkg::q32_t               t_new;
    logic [63:0]                 df_mag;

    ecf_pkg::alu_req_t           alu_req;
    ecf_pkg::alu_rsp_t           alu_rsp;

    function automatic ecf_pkg::q32_t port_to_q32(logic [31:0] v);
        return ecf_pkg::q32_t'({{16{v[31]}}, v, 16'd0});
    endfunction

    function automatic logic [31:0] q32_to_port(ecf_pkg::q32_t v);
        logic [63:0] m;
        logic [48:0] r;
        logic [31:0] o;
        m = v[63] ? (64'd0 - 64'(v)) : 64'(v);
        r = {1'b0, m[63:16]} + {48'd0, m[15]};
        if (v[63])
        begin
            o = (r > 49'h0_8000_0000) ? 32'h8000_0000 : (32'd0 - r[31:0]);
        end
        else
        begin
            o = (r > 49'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : r[31:0];
        end
        return o;
    endfunction

    assign inst   = ecf_pkg::ucode(pc_reg);
    assign busy   = (state_reg != S_IDLE);
    assign df_mag = rda_reg[63] ? (64'd0 - 64'(rda_reg)) : 64'(rda_reg);

    always_comb
    begin
        unique case (load_reg)
            4'd0:    load_val = port_to_q32(item_reg.offset_x);
            4'd1:    load_val = port_to_q32(item_reg.offset_y);
            4'd2:    load_val = port_to_q32(item_reg.first_m11);
            4'd3:    load_val = port_to_q32(item_reg.first_m12);
            4'd4:    load_val = port_to_q32(item_reg.first_m21);
            4'd5:    load_val = port_to_q32(item_reg.first_m22);
            4'd6:    load_val = port_to_q32(item_reg.second_m11);
            4'd7:    load_val = port_to_q32(item_reg.second_m12);
            4'd8:    load_val = port_to_q32(item_reg.second_m21);
            4'd9:    load_val = port_to_q32(item_reg.second_m22);
            4'd10:   load_val = ecf_pkg::HALF_Q32;
            default: load_val = ecf_pkg::ONE_Q32;
        endcase
    end

    always_comb
    begin
        if (rdb_reg < 0)
        begin
            t_new = rda_reg >>> 1;
        end
        else if (rdb_reg > ecf_pkg::ONE_Q32)
        begin
            t_new = (rda_reg + ecf_pkg::ONE_Q32) >>> 1;
        end
        else
        begin
            t_new = rdb_reg;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        pc_next     = pc_reg;
        iter_next   = iter_reg;
        load_next   = load_reg;
        res_next    = res_reg;
        done_next   = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = inst.dst;
        wr_data     = alu_rsp.y;
        alu_req.start = 1'b0;
        alu_req.op    = ecf_pkg::ALU_ADD;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    load_next  = '0;
                    pc_next    = '0;
                    iter_next  = '0;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                wr_en     = 1'b1;
                wr_addr   = ecf_pkg::raddr_t'(load_reg);
                wr_data   = load_val;
                load_next = load_reg + 4'd1;
                if (load_reg == 4'd11)
                begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                state_next = S_OPER;
            end
            S_OPER:
            begin
                unique case (inst.op)
                    ecf_pkg::U_ADD, ecf_pkg::U_SUB, ecf_pkg::U_NEG,
                    ecf_pkg::U_MUL, ecf_pkg::U_DIV:
                    begin
                        alu_req.start = 1'b1;
                        unique case (inst.op)
                            ecf_pkg::U_SUB: alu_req.op = ecf_pkg::ALU_SUB;
                            ecf_pkg::U_NEG: alu_req.op = ecf_pkg::ALU_NEG;
                            ecf_pkg::U_MUL: alu_req.op = ecf_pkg::ALU_MUL;
                            ecf_pkg::U_DIV: alu_req.op = ecf_pkg::ALU_DIV;
                            default:        alu_req.op = ecf_pkg::ALU_ADD;
                        endcase
                        state_next = S_WAIT;
                    end
                    ecf_pkg::U_CHKDET:
                    begin
                        if (rda_reg == 0)
                        begin
                            res_next.contact_value = ecf_pkg::PORT_POS_SAT;
                            res_next.finish_status = ecf_pkg::ST_NO_CONV;
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            pc_next    = pc_reg + PC_STEP;
                            state_next = S_FETCH;
                        end
                    end
                    ecf_pkg::U_TEST:
                    begin
                        priority if (df_mag < {32'd0, tol_reg})
                        begin
                            res_next.contact_value = q32_to_port(rdb_reg);
                            res_next.finish_status = ecf_pkg::ST_CONVERGED;
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                        else if (rdb_reg > ecf_pkg::ONE_Q32)
                        begin
                            res_next.contact_value = q32_to_port(rdb_reg);
                            res_next.finish_status = ecf_pkg::ST_SEPARATED;
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            pc_next    = pc_reg + PC_STEP;
                            state_next = S_FETCH;
                        end
                    end
                    default:
                    begin
                        wr_en   = 1'b1;
                        wr_data = t_new;
                        pc_next = '0;
                        if (iter_reg == IW'(ITERATIONS - 1))
                        begin
                            res_next.contact_value = ecf_pkg::PORT_MINUS_ONE;
                            res_next.finish_status = ecf_pkg::ST_NO_CONV;
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            iter_next  = iter_reg + IW'(1);
                            state_next = S_FETCH;
                        end
                    end
                endcase
            end
            S_WAIT:
            begin
                if (alu_rsp.done)
                begin
                    wr_en      = 1'b1;
                    pc_next    = pc_reg + PC_STEP;
                    state_next = S_FETCH;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    ecf_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .a     (rda_reg),
        .b     (rdb_reg),
        .rsp   (alu_rsp)
    );

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rf[wr_addr] <= wr_data;
        end
        rda_reg <= rf[inst.a];
        rdb_reg <= rf[inst.b];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pc_reg    <= '0;
            iter_reg  <= '0;
            load_reg  <= '0;
            done_reg  <= 1'b0;
            tol_reg   <= ecf_pkg::TOL_RESET;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            iter_reg  <= iter_next;
            load_reg  <= load_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                tol_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (start && !busy)
        begin
            item_reg <= item;
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

// ===== hw/rtl/ecf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ellipse contact function port checker
// Watches the top-level ports for the command and result beat ordering and for a legal result status.
// ----------------------------------------------------------------------------
module ecf_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                done,
    input ecf_pkg::out_beat_t  result
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("Accepted item did not raise busy.");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("Result beat without an item in work.");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("Result beat lasted more than one cycle.");

    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.finish_status == ecf_pkg::ST_CONVERGED
               || result.finish_status == ecf_pkg::ST_SEPARATED
               || result.finish_status == ecf_pkg::ST_NO_CONV))
        else $error("Result beat carries an unknown status.");

endmodule

bind ellipse_contact_function ecf_checker u_ecf_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
